/* ufwrl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the user fixed-window rate limiter.
// No dependencies; the controller, datapath and top level import it.
package ufwrl_pkg;

    // Direct-mapped user table
    localparam int TABLE_ENTRIES = 2048;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int ID_W          = 64;
    localparam int TAG_W         = 63;
    localparam int TIME_W        = 32;
    localparam int CNT_W         = 16;

    // Configuration registers
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT = 1'b1;
    localparam logic [CFG_W-1:0]     RESET_WINDOW      = 16'd60;
    localparam logic [CFG_W-1:0]     RESET_LIMIT       = 16'd30;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // One table row
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] start;
        logic [CNT_W-1:0]  count;
    } ufwrl_entry_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC
    } ufwrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clr_we;   // write one cleared row
        logic capture;  // accept a request and read its row
        logic commit;   // write the row back and load the result
    } ufwrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clr_last; // clearing pointer at the final row
        logic out_free; // result register can take a new result
    } ufwrl_sts_t;

endpackage

/* design/ufwrl_ctrl.sv */
`timescale 1ns / 1ps
// Controller for the rate limiter: clearing pass, request accept, write-back.
// Depends on ufwrl_pkg for the state, command and status types.
module ufwrl_ctrl import ufwrl_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ufwrl_sts_t sts,
    output ufwrl_cmd_t cmd
);

    ufwrl_state_t state_reg;
    ufwrl_state_t state_next;

    // Hold the current state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Advance through clear, idle and calculation
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) state_next = ST_CALC;
            end
            ST_CALC: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Drive handshake and datapath commands
    always_comb begin
        s_ready     = 1'b0;
        cmd.clr_we  = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_we = 1'b1;
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_CALC: begin
                cmd.commit = sts.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* design/ufwrl_datapath.sv */
`timescale 1ns / 1ps
// Datapath for the rate limiter: user table memory, window and count update,
// configuration registers and the result register. Depends on ufwrl_pkg.
module ufwrl_datapath import ufwrl_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ufwrl_cmd_t              cmd,
    output ufwrl_sts_t              sts,
    input  logic signed [ID_W-1:0]  s_user_id,
    input  logic [TIME_W-1:0]       s_now_seconds,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_over_limit,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    ufwrl_entry_t mem [TABLE_ENTRIES];

    logic [CFG_W-1:0]       window_length_reg;
    logic [CFG_W-1:0]       request_limit_reg;
    logic [IDX_W-1:0]       clr_addr_reg;
    logic signed [ID_W-1:0] id_reg;
    logic [TIME_W-1:0]      now_reg;
    ufwrl_entry_t           rd_data_reg;
    logic                   m_valid_reg;
    logic                   m_over_reg;

    logic                   bypass;
    logic                   hit;
    logic [TIME_W-1:0]      elapsed;
    logic                   restart;
    logic [CNT_W-1:0]       base_count;
    logic [CNT_W-1:0]       cnt_next;
    logic                   over_next;
    ufwrl_entry_t           entry_next;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    ufwrl_entry_t           mem_wdata;

    // Accept configuration writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= RESET_WINDOW;
            request_limit_reg <= RESET_LIMIT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH: window_length_reg <= cfg_data;
                REG_REQUEST_LIMIT: request_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Step the clearing pointer over the table after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_we) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign sts.clr_last = (clr_addr_reg == {IDX_W{1'b1}});

    // Capture the request transaction
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            id_reg  <= s_user_id;
            now_reg <= s_now_seconds;
        end
    end

    // Read the selected row, registered
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rd_data_reg <= mem[s_user_id[IDX_W-1:0]];
        end
    end

    // Decide restart, bump the count with saturation, flag over-limit
    always_comb begin
        bypass     = (id_reg == '0) || id_reg[ID_W-1];
        hit        = (rd_data_reg.tag == id_reg[TAG_W-1:0]);
        elapsed    = now_reg - rd_data_reg.start;
        restart    = !hit || (elapsed >= {{(TIME_W-CFG_W){1'b0}}, window_length_reg});
        base_count = restart ? '0 : rd_data_reg.count;
        cnt_next   = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + 1'b1;
        over_next  = !bypass && (cnt_next > request_limit_reg);

        entry_next.tag   = id_reg[TAG_W-1:0];
        entry_next.start = restart ? now_reg : rd_data_reg.start;
        entry_next.count = cnt_next;
    end

    // Select between clearing rows and writing back a request
    always_comb begin
        if (cmd.clr_we) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = cmd.commit && !bypass;
            mem_waddr = id_reg[IDX_W-1:0];
            mem_wdata = entry_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Hold the result until the output transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_over_reg <= over_next;
        end
    end

    assign sts.out_free  = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_over_limit  = m_over_reg;

    // Clearing pass never overlaps request work
    a_clear_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clr_we |-> !(cmd.capture || cmd.commit))
        else $error("table clear overlaps request processing");

    // A bypassed request always yields an allowed result
    a_bypass_allowed: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && bypass) |=> (m_valid_reg && !m_over_reg))
        else $error("bypassed request flagged over limit");

    // Requests are spaced so a write-back lands before the next read
    a_capture_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> !cmd.capture)
        else $error("request captured during read-modify-write");

endmodule

/* design/user_fixed_window_rate_limiter_unit.sv */
`timescale 1ns / 1ps
// Top level of the user fixed-window rate limiter.
// Depends on ufwrl_pkg, ufwrl_ctrl and ufwrl_datapath.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_user_id[63:0] signed, s_now_seconds[31:0]
//  m_       out        m_valid / m_ready    m_over_limit
//  cfg_     in         cfg_valid/cfg_ready  cfg_index[0:0], cfg_data[15:0]
//
// For each request the accept edge reads its table row into a register; the row
// is written back and the result register loaded once the result register is free.
// After reset a clearing pass writes one row a cycle over all TABLE_ENTRIES (2048)
// rows with s_ready low; configuration writes are taken throughout.
// With m_ready low the result is held, one further request may be accepted
// and waits for write-back until the result register frees.
module user_fixed_window_rate_limiter_unit import ufwrl_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [ID_W-1:0]  s_user_id,
    input  logic [TIME_W-1:0]       s_now_seconds,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_over_limit,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data
);

    ufwrl_cmd_t cmd;
    ufwrl_sts_t sts;

    // Sequence clearing and request transactions
    ufwrl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table, update logic and registers
    ufwrl_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_user_id     (s_user_id),
        .s_now_seconds (s_now_seconds),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_over_limit  (m_over_limit),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

endmodule
